FILE: rtl/rsb_pkg.sv
// Package for the reply segment batcher.
// Word types, per-port entry layout, register indexes and reset values.
// No dependencies.
package rsb_pkg;

  // Number of ports with a pending batch
  localparam int NUM_PORTS = 8;
  localparam int IDX_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Field widths
  localparam int PORT_W  = 3;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 32;
  localparam int BYTES_W = 17;
  localparam int SEGS_W  = 8;
  localparam int TMO_W   = 24;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  // Saturation values of the batch counters
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [SEGS_W-1:0]  SEGS_MAX  = {SEGS_W{1'b1}};

  // Opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_SIZE_LIMIT    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SEGMENT_LIMIT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT_US    = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]  SIZE_LIMIT_RST    = 16'd9014;
  localparam logic [SEGS_W-1:0] SEGMENT_LIMIT_RST = 8'd50;
  localparam logic [TMO_W-1:0]  TIMEOUT_US_RST    = 24'd20000;

  typedef struct packed {
    logic              opcode;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  seg_len;
    logic [TIME_W-1:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic               flush_valid;
    logic [PORT_W-1:0]  flush_port;
    logic [BYTES_W-1:0] flush_bytes;
    logic [SEGS_W-1:0]  flush_segments;
    logic [SEGS_W-1:0]  pending_segments;
  } out_word_t;

  // One port's pending batch
  typedef struct packed {
    logic               open;
    logic [BYTES_W-1:0] bytes;
    logic [SEGS_W-1:0]  segments;
    logic [TIME_W-1:0]  last_flush;
  } entry_t;

  // Write request into the state memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } entry_wr_t;

  // Configuration register set
  typedef struct packed {
    logic [LEN_W-1:0]  size_limit;
    logic [SEGS_W-1:0] segment_limit;
    logic [TMO_W-1:0]  timeout_us;
  } cfg_t;

endpackage

FILE: rtl/reply_segment_batcher.sv
// Reply segment batcher top level: control, config registers, output register.
// Uses rsb_pkg, rsb_state_ram and rsb_update.

// Coalesces reply segments into one pending batch per port and emits one
// result word per input word (flush_valid tells whether a batch went out).
// The port's entry is first read from the state memory (registered read),
// then updated, written back and loaded into the result register. The load
// waits while a result is stalled, and no new word is accepted before it.
// The result register is separate from the input side: a word is accepted
// while the previous result is still waiting. No clearing pass is needed
// after reset. Configuration writes are taken at any edge with cfg_we high
// and must only be issued while the block is idle.
module reply_segment_batcher
  import rsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic       state;
  logic       state_next;
  cfg_t       cfg;
  in_word_t   item;
  entry_t     rd_entry;
  entry_t     entry_next;
  entry_wr_t  wr;
  out_word_t  result;
  logic       port_ok;
  logic       in_accept;
  logic       can_load;
  logic       load;
  logic [IDX_W-1:0] rd_addr;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign can_load  = !out_valid || !out_stall;
  assign load      = (state == ST_READ) && can_load;

  // Read address: new word's port on accept, else hold the current one
  assign rd_addr = in_accept ? IDX_W'(in_data.port) : IDX_W'(item.port);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_limit    <= SIZE_LIMIT_RST;
      cfg.segment_limit <= SEGMENT_LIMIT_RST;
      cfg.timeout_us    <= TIMEOUT_US_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_LIMIT:    cfg.size_limit    <= cfg_data[LEN_W-1:0];
        REG_SEGMENT_LIMIT: cfg.segment_limit <= cfg_data[SEGS_W-1:0];
        REG_TIMEOUT_US:    cfg.timeout_us    <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_accept) state_next = ST_READ;
      ST_READ: if (can_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured input word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= in_data;
    end
  end

  rsb_state_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  rsb_update u_update (
    .cfg        (cfg),
    .item       (item),
    .entry      (rd_entry),
    .port_ok    (port_ok),
    .entry_next (entry_next),
    .result     (result)
  );

  // Write back on the update cycle
  assign wr.en   = load && port_ok;
  assign wr.addr = IDX_W'(item.port);
  assign wr.data = entry_next;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/rsb_state_ram.sv
// Per-port batch state memory with a registered read.
// Valid bits cleared by reset make unwritten entries read as zero. Uses rsb_pkg.
module rsb_state_ram
  import rsb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_entry,
  input  entry_wr_t        wr
);

  entry_t               mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] entry_valid;
  entry_t               rd_data;
  logic                 rd_valid;

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits, one per entry
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      rd_valid <= entry_valid[rd_addr];
    end
  end

  assign rd_entry = rd_valid ? rd_data : '0;

endmodule

FILE: rtl/rsb_update.sv
// Batch update logic: flush decision, segment append and result word.
// Purely combinational over one entry. Uses rsb_pkg.
module rsb_update
  import rsb_pkg::*;
(
  input  cfg_t      cfg,
  input  in_word_t  item,
  input  entry_t    entry,
  output logic      port_ok,
  output entry_t    entry_next,
  output out_word_t result
);

  logic [BYTES_W:0]  sum;
  logic [TIME_W-1:0] age;
  logic              seg_full;
  logic              too_big;
  logic              timed_out;
  logic              flush;
  entry_t            upd;

  assign port_ok   = (32'(item.port) < 32'(NUM_PORTS));
  assign sum       = (BYTES_W + 1)'(entry.bytes) + (BYTES_W + 1)'(item.seg_len);
  assign age       = item.now_us - entry.last_flush;
  assign seg_full  = (entry.segments >= cfg.segment_limit);
  assign too_big   = (sum > (BYTES_W + 1)'(cfg.size_limit));
  assign timed_out = (age >= TIME_W'(cfg.timeout_us));

  // Flush decision per opcode
  always_comb begin
    case (item.opcode)
      OP_APPEND: flush = entry.open && (too_big || seg_full);
      OP_POLL:   flush = entry.open && (seg_full || timed_out);
      default:   flush = 1'b0;
    endcase
  end

  // New entry value
  always_comb begin
    upd = entry;
    if (flush) begin
      upd.open       = 1'b0;
      upd.bytes      = '0;
      upd.segments   = '0;
      upd.last_flush = item.now_us;
    end
    if (item.opcode == OP_APPEND) begin
      if (!entry.open || flush) begin
        // start a fresh batch with this segment
        upd.open     = 1'b1;
        upd.bytes    = BYTES_W'(item.seg_len);
        upd.segments = SEGS_W'(1);
      end else begin
        upd.bytes = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
        if (entry.segments != SEGS_MAX) begin
          upd.segments = entry.segments + SEGS_W'(1);
        end
      end
    end
  end

  assign entry_next = upd;

  // Result word; all zero for a port out of range
  always_comb begin
    result = '0;
    if (port_ok) begin
      result.pending_segments = upd.segments;
      if (flush) begin
        result.flush_valid    = 1'b1;
        result.flush_port     = item.port;
        result.flush_bytes    = entry.bytes;
        result.flush_segments = entry.segments;
      end
    end
  end

endmodule
